// ----- design/pph_pkg.sv -----
// Package for the pulse period histogram unit.
// Holds the shared widths, op codes, register indexes, reset values and the
// command and status structs. No dependencies.
package pph_pkg;

  localparam int unsigned BINS_DEFAULT = 128;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Item op codes.
  localparam logic [OP_W-1:0] OP_EDGE    = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TARGET = 2'd2;

  localparam logic [DATA_W-1:0] PERIOD_LOW_RESET    = 16'd950;
  localparam logic [DATA_W-1:0] PERIOD_HIGH_RESET   = 16'd1050;
  localparam logic [DATA_W-1:0] SAMPLE_TARGET_RESET = 16'd1000;
  localparam logic [DATA_W-1:0] BIN_MAX             = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_we;
    logic load_item;
    logic calc;
    logic lookup;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

// ----- design/pph_in_if.sv -----
// Input item channel of the pulse period histogram unit.
// Valid/ready handshake with the item payload; depends on pph_pkg.
interface pph_in_if import pph_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DATA_W-1:0] timestamp;
  logic [IDX_W-1:0]  bin_index;

  modport source (output valid, op, timestamp, bin_index, input ready);
  modport sink (input valid, op, timestamp, bin_index, output ready);
endinterface

// ----- design/pph_out_if.sv -----
// Result channel of the pulse period histogram unit.
// Valid/ready handshake with the result payload; depends on pph_pkg.
interface pph_out_if import pph_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] period;
  logic              counted;
  logic [DATA_W-1:0] bin_count;
  logic [DATA_W-1:0] sample_count;
  logic              done_res;
  logic              edge_seen;

  modport source (output valid, period, counted, bin_count, sample_count, done_res,
                  edge_seen, input ready);
  modport sink (input valid, period, counted, bin_count, sample_count, done_res,
                edge_seen, output ready);
endinterface

// ----- design/pph_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pph_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/pph_ctrl.sv -----
// Controller of the pulse period histogram unit: sequences the clearing pass
// and each item through evaluate, lookup and commit. Depends on pph_pkg.
module pph_ctrl import pph_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.calc   = 1'b1;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/pph_datapath.sv -----
// Datapath of the pulse period histogram unit: configuration registers,
// capture state, period arithmetic, histogram RAM and result registers.
// Depends on pph_pkg and pph_ram.
module pph_datapath import pph_pkg::*; #(
  parameter int unsigned BINS = BINS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [OP_W-1:0]      in_op,
  input  logic [DATA_W-1:0]    in_timestamp,
  input  logic [IDX_W-1:0]     in_bin_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output logic [DATA_W-1:0]    period,
  output logic                 counted,
  output logic [DATA_W-1:0]    bin_count,
  output logic [DATA_W-1:0]    sample_count,
  output logic                 done_res,
  output logic                 edge_seen
);

  localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [DATA_W-1:0] BINS_W = DATA_W'(BINS);

  logic [DATA_W-1:0] period_low;
  logic [DATA_W-1:0] period_high;
  logic [DATA_W-1:0] sample_target;

  logic [DATA_W-1:0] last_stamp;
  logic              stamp_valid;
  logic [DATA_W-1:0] samples;
  logic              edge_flag;

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] stamp_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] period_q;
  logic              hit_q;
  logic              bin_ok_q;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     clr_addr;

  logic [DATA_W-1:0] offset;
  logic [DATA_W-1:0] idx_ext;
  logic [DATA_W-1:0] sel_addr;
  logic              hit;
  logic              bin_ok;

  logic [DATA_W-1:0] last_stamp_next;
  logic              stamp_valid_next;
  logic [DATA_W-1:0] samples_next;
  logic              edge_flag_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  // Bin selection, done in the lookup step from the registered period.
  assign offset   = period_q - period_low;
  assign idx_ext  = DATA_W'(idx_q);
  assign hit      = (op_q == OP_EDGE) && stamp_valid && (samples < sample_target) &&
                    (period_q >= period_low) && (period_q <= period_high) &&
                    (offset < BINS_W);
  assign bin_ok   = (op_q == OP_READ) && (idx_ext < BINS_W);
  assign sel_addr = (op_q == OP_EDGE) ? offset : idx_ext;

  assign status.clear_last = (clr_addr == AW'(BINS - 1));

  always_comb begin
    last_stamp_next  = last_stamp;
    stamp_valid_next = stamp_valid;
    samples_next     = samples;
    edge_flag_next   = edge_flag;
    unique case (op_q)
      OP_EDGE: begin
        last_stamp_next  = stamp_q;
        stamp_valid_next = 1'b1;
        edge_flag_next   = 1'b1;
        if (hit_q) begin
          samples_next = samples + 16'd1;
        end
      end
      OP_RESTART: begin
        last_stamp_next  = '0;
        stamp_valid_next = 1'b0;
        samples_next     = '0;
        edge_flag_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Write port: zero fill during the clearing pass, else the commit update.
  always_comb begin
    ram_we    = cmd.clear_we || (cmd.commit && (hit_q || bin_ok_q));
    ram_waddr = cmd.clear_we ? clr_addr : addr_q;
    ram_wdata = '0;
    if (!cmd.clear_we && hit_q) begin
      ram_wdata = (ram_rdata == BIN_MAX) ? BIN_MAX : ram_rdata + 16'd1;
    end
  end

  pph_ram #(
    .WIDTH(DATA_W),
    .DEPTH(BINS)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.lookup),
    .raddr(sel_addr[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period_low    <= PERIOD_LOW_RESET;
      period_high   <= PERIOD_HIGH_RESET;
      sample_target <= SAMPLE_TARGET_RESET;
      last_stamp    <= '0;
      stamp_valid   <= 1'b0;
      samples       <= '0;
      edge_flag     <= 1'b0;
      clr_addr      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PERIOD_LOW:    period_low    <= cfg_data;
          REG_PERIOD_HIGH:   period_high   <= cfg_data;
          REG_SAMPLE_TARGET: sample_target <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.clear_we) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.commit) begin
        last_stamp  <= last_stamp_next;
        stamp_valid <= stamp_valid_next;
        samples     <= samples_next;
        edge_flag   <= edge_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q    <= in_op;
      stamp_q <= in_timestamp;
      idx_q   <= in_bin_index;
    end
    if (cmd.calc) begin
      period_q <= stamp_valid ? (stamp_q - last_stamp) : '0;
    end
    if (cmd.lookup) begin
      hit_q    <= hit;
      bin_ok_q <= bin_ok;
      addr_q   <= sel_addr[AW-1:0];
    end
    if (cmd.commit) begin
      period       <= (op_q == OP_EDGE) ? period_q : '0;
      counted      <= hit_q;
      bin_count    <= bin_ok_q ? ram_rdata : '0;
      sample_count <= samples_next;
      done_res     <= (samples_next >= sample_target);
      edge_seen    <= edge_flag_next;
    end
  end

endmodule

// ----- design/pulse_period_histogram_unit.sv -----
// Top level of the pulse period histogram unit.
// Depends on pph_pkg, pph_in_if, pph_out_if, pph_ctrl and pph_datapath.
//
//   channel   direction  handshake            payload
//   items     in         valid/ready          op, timestamp, bin_index
//   results   out        valid/ready          period, counted, bin_count,
//                                             sample_count, done_res, edge_seen
//   cfg       in         cfg_we (no wait)     cfg_index, cfg_data
//
// Each item goes from one transfer on items to the next through idle, where
// it is accepted, then evaluate, lookup and commit; the sequence is set by
// the read-modify-write of the histogram RAM through its registered read port.
// After reset the unit runs a clearing pass over each address of the histogram
// RAM, during which items is not ready; configuration writes are taken at once.
// The result register frees the input side: a new item is accepted while the
// last result still waits, and only the commit step stalls until it is taken.
module pulse_period_histogram_unit import pph_pkg::*; #(
  parameter int unsigned BINS = BINS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  pph_in_if.sink               items,
  pph_out_if.source            results,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cmd_t    cmd;
  status_t status;

  // The controller owns the handshakes and the step sequence.
  pph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds all state and the result payload registers.
  pph_datapath #(
    .BINS(BINS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_op       (items.op),
    .in_timestamp(items.timestamp),
    .in_bin_index(items.bin_index),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .period      (results.period),
    .counted     (results.counted),
    .bin_count   (results.bin_count),
    .sample_count(results.sample_count),
    .done_res    (results.done_res),
    .edge_seen   (results.edge_seen)
  );

  // The unit works on one item at a time, so it is busy right after a transfer.
  assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("item accepted while the previous one is still in progress");

  // A commit must never overwrite a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!results.valid || results.ready))
    else $error("commit overwrote a pending result");

  // A counted edge has been seen and has raised the sample count.
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.counted) |->
      (results.edge_seen && (results.sample_count != '0)))
    else $error("counted result without edge or sample");

  // Only a bin read returns a bin count, and it never carries a period.
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.bin_count != '0)) |->
      ((results.period == '0) && !results.counted))
    else $error("bin count reported on a non-read result");

endmodule
